/* rtl/assert_macros.svh */
// Assertion macros used by the top level of the byte pattern scanner.
// No dependencies; define SYNTH to compile the macros away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_HOLDS(lbl, clk_s, rst_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) \
        else $error("assertion failed: %m");
`define ASSERT_IMPLIES(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("implication failed: %m");
`else
`define ASSERT_HOLDS(lbl, clk_s, rst_s, prop)
`define ASSERT_IMPLIES(lbl, clk_s, rst_s, ante, cons)
`endif
`endif

/* rtl/wbps_pkg.sv */
// Package of the wildcard byte pattern scanner: constants, register codes and types.
// No dependencies; used by wbps_cell and the top level.
package wbps_pkg;

    localparam int DEPTH_DEFAULT = 128;
    localparam int GROUP_SIZE    = 16;

    localparam logic [7:0] LENGTH_RESET = 8'd1;
    localparam logic [6:0] LIMIT_RESET  = 7'd50;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_SCAN = 1'b1;

    typedef enum logic [1:0] {
        REG_REGION_BASE    = 2'd0,
        REG_PATTERN_LENGTH = 2'd1,
        REG_MATCH_LIMIT    = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic       care;
        logic [7:0] value;
    } pat_entry_t;

    typedef struct packed {
        logic win_shift;
        logic ap_shift;
        logic ap_write;
        logic ok_en;
    } cell_ctrl_t;

endpackage

/* rtl/wbps_cell.sv */
// One cell of the scanner chain: a window byte, the pattern entry aligned to it,
// and a registered compare result. Depends on wbps_pkg.
module wbps_cell (
    input  logic                   clk,
    input  wbps_pkg::cell_ctrl_t   ctrl,
    input  logic                   sel,
    input  logic                   active,
    input  logic [7:0]             win_in,
    input  wbps_pkg::pat_entry_t   ap_in,
    input  wbps_pkg::pat_entry_t   ap_wr,
    output logic [7:0]             win_out,
    output wbps_pkg::pat_entry_t   ap_out,
    output logic                   ok
);
    import wbps_pkg::*;

    logic [7:0] win_reg;
    pat_entry_t ap_reg;
    logic       ok_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.win_shift)
        begin
            win_reg <= win_in;
        end
        if (ctrl.ap_shift)
        begin
            ap_reg <= ap_in;
        end
        else if (ctrl.ap_write && sel)
        begin
            ap_reg <= ap_wr;
        end
        // Cells beyond the pattern length and wildcard entries always agree.
        if (ctrl.ok_en)
        begin
            ok_reg <= !(active && ap_reg.care && (win_reg != ap_reg.value));
        end
    end

    assign win_out = win_reg;
    assign ap_out  = ap_reg;
    assign ok      = ok_reg;

endmodule

/* rtl/wildcard_byte_pattern_scanner.sv */
// Top level of the wildcard byte pattern scanner: cell chain, pattern memory,
// register port and result pipeline. Depends on wbps_pkg, wbps_cell, assert_macros.svh.
//
// Usage: configure region_base, pattern_length and match_limit over the APB port
// (byte addresses 0, 8 and 16). Items enter on item_valid/item_stall: mode 0 loads
// one pattern entry, mode 1 scans one data byte (region_start marks the first byte
// of a region). Each item gives exactly one result on result_valid/result_stall.
// Throughput is one item per clock while item_stall is low. A result passes in order
// through the window register, the cell compare stage, the group AND stage and the
// output register. A write to pattern_length realigns the cell chain from the pattern
// memory, one entry a cycle through its single read port: item_stall stays high after
// that write until the entries for the length in use (zero counts as one, capped at
// the depth) have all been read and shifted into the chain.
// When result_stall is high with a result waiting, the whole pipeline holds and
// item_stall rises; no item is lost. Reset clears the registers to their defaults
// (base 0, length 1, limit 50), the window fill, offset and match count, and
// empties the pipeline. Pattern entries are undefined until loaded.
`include "assert_macros.svh"

module wildcard_byte_pattern_scanner #(
    parameter int PATTERN_DEPTH = wbps_pkg::DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    // item channel
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        mode,
    input  logic [6:0]  entry_index,
    input  logic [7:0]  entry_byte,
    input  logic        entry_care,
    input  logic [7:0]  data_byte,
    input  logic        region_start,
    // result channel
    output logic        result_valid,
    input  logic        result_stall,
    output logic        match_found,
    output logic [63:0] match_address,
    output logic [6:0]  match_count,
    output logic        limit_reached
);
    import wbps_pkg::*;

    localparam int LW = $clog2(PATTERN_DEPTH + 1);
    localparam int IW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
    localparam int NG = (PATTERN_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

    typedef struct packed {
        logic        is_scan;
        logic        region_start;
        logic        filled;
        logic [63:0] addr;
    } meta_t;

    // configuration and control state
    logic [63:0] region_base_reg, region_base_next;
    logic [7:0]  pattern_length_reg, pattern_length_next;
    logic [6:0]  match_limit_reg, match_limit_next;
    logic        sweep_active_reg, sweep_active_next;
    logic [LW-1:0] sweep_cnt_reg, sweep_cnt_next;
    logic        rd_pend_reg, rd_pend_next;
    logic [LW-1:0] fill_reg, fill_next;
    logic [63:0] offset_reg, offset_next;
    logic        v0_reg, v0_next;
    logic        v1_reg, v1_next;
    logic        v2_reg, v2_next;
    logic        out_valid_reg, out_valid_next;
    logic [6:0]  count_reg, count_next;

    // payload
    meta_t       m0_reg, m1_reg, m2_reg;
    logic [NG-1:0] group_reg;
    logic        match_found_reg;
    logic [63:0] match_address_reg;
    logic [6:0]  match_count_reg;
    logic        limit_reg;
    pat_entry_t  pat_mem [PATTERN_DEPTH];
    pat_entry_t  pat_rdata_reg;

    // combinational
    logic        cfg_wr;
    logic [1:0]  cfg_idx;
    logic [31:0] len_wide;
    logic [LW-1:0] len_used;
    logic [LW-1:0] len_last;
    logic        adv;
    logic        sweep_busy;
    logic        item_acc;
    logic        scan_acc;
    logic        load_acc;
    logic        idx_in_range;
    logic        load_hits;
    logic [LW-1:0] load_tgt;
    pat_entry_t  load_entry;
    logic [63:0] off_eff;
    logic [LW-1:0] fill_eff;
    logic [LW-1:0] fill_after;
    meta_t       m0_new;
    meta_t       m2_new;
    logic [6:0]  cnt_base;
    logic        hit;
    logic [6:0]  cnt_new;
    cell_ctrl_t  cell_ctrl;
    logic [7:0]  win_chain [PATTERN_DEPTH];
    pat_entry_t  ap_chain [PATTERN_DEPTH];
    logic [PATTERN_DEPTH-1:0] ok_vec;
    logic [NG*GROUP_SIZE-1:0] ok_pad;
    logic [NG-1:0] group_and;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:3];

    always_comb
    begin
        case (cfg_idx)
            REG_REGION_BASE:    prdata = region_base_reg;
            REG_PATTERN_LENGTH: prdata = {56'd0, pattern_length_reg};
            REG_MATCH_LIMIT:    prdata = {57'd0, match_limit_reg};
            default:            prdata = 64'd0;
        endcase
    end

    // A length of zero acts as one, and anything beyond the depth as the depth.
    always_comb
    begin
        len_wide = 32'(pattern_length_reg);
        if (len_wide == 32'd0)
        begin
            len_wide = 32'd1;
        end
        if (len_wide > 32'(PATTERN_DEPTH))
        begin
            len_wide = 32'(PATTERN_DEPTH);
        end
    end
    assign len_used = len_wide[LW-1:0];
    assign len_last = len_used - LW'(1);

    assign sweep_busy = sweep_active_reg || rd_pend_reg;
    assign adv        = !(out_valid_reg && result_stall);
    assign item_stall = !adv || sweep_busy;
    assign item_acc   = item_valid && !item_stall;
    assign scan_acc   = item_acc && (mode == MODE_SCAN);
    assign load_acc   = item_acc && (mode == MODE_LOAD);

    assign idx_in_range = 32'(entry_index) < 32'(PATTERN_DEPTH);
    assign load_hits    = 32'(entry_index) < 32'(len_used);
    // Pattern entry i lines up with the cell that holds the byte len-1-i back.
    assign load_tgt     = len_last - LW'(entry_index);
    assign load_entry   = '{care: entry_care, value: entry_byte};

    always_comb
    begin
        off_eff    = region_start ? 64'd0 : offset_reg;
        fill_eff   = region_start ? '0 : fill_reg;
        fill_after = (fill_eff == LW'(PATTERN_DEPTH)) ? fill_eff : fill_eff + LW'(1);
        m0_new.is_scan      = (mode == MODE_SCAN);
        m0_new.region_start = region_start;
        m0_new.filled       = fill_after >= len_used;
        m0_new.addr         = off_eff - 64'(len_last);
    end

    always_comb
    begin
        m2_new      = m1_reg;
        m2_new.addr = region_base_reg + m1_reg.addr;
    end

    // Final stage: match decision against the running count.
    always_comb
    begin
        cnt_base = (m2_reg.is_scan && m2_reg.region_start) ? 7'd0 : count_reg;
        hit      = m2_reg.is_scan && m2_reg.filled && (&group_reg)
                   && (cnt_base < match_limit_reg);
        cnt_new  = hit ? cnt_base + 7'd1 : cnt_base;
    end

    always_comb
    begin
        region_base_next    = region_base_reg;
        pattern_length_next = pattern_length_reg;
        match_limit_next    = match_limit_reg;
        sweep_active_next   = sweep_active_reg;
        sweep_cnt_next      = sweep_cnt_reg;
        rd_pend_next        = sweep_active_reg;
        fill_next           = fill_reg;
        offset_next         = offset_reg;
        v0_next             = v0_reg;
        v1_next             = v1_reg;
        v2_next             = v2_reg;
        out_valid_next      = out_valid_reg;
        count_next          = count_reg;

        if (cfg_wr)
        begin
            case (cfg_idx)
                REG_REGION_BASE:    region_base_next = pwdata;
                REG_PATTERN_LENGTH: pattern_length_next = pwdata[7:0];
                REG_MATCH_LIMIT:    match_limit_next = pwdata[6:0];
                default:            ;
            endcase
        end

        if (sweep_active_reg)
        begin
            sweep_cnt_next = sweep_cnt_reg + LW'(1);
            if (sweep_cnt_reg == len_last)
            begin
                sweep_active_next = 1'b0;
            end
        end
        // A new length restarts the realignment from entry zero.
        if (cfg_wr && (cfg_idx == REG_PATTERN_LENGTH))
        begin
            sweep_active_next = 1'b1;
            sweep_cnt_next    = '0;
        end

        if (scan_acc)
        begin
            fill_next   = fill_after;
            offset_next = off_eff + 64'd1;
        end

        if (adv)
        begin
            v0_next        = item_acc;
            v1_next        = v0_reg;
            v2_next        = v1_reg;
            out_valid_next = v2_reg;
            if (v2_reg)
            begin
                count_next = cnt_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_base_reg    <= 64'd0;
            pattern_length_reg <= LENGTH_RESET;
            match_limit_reg    <= LIMIT_RESET;
            sweep_active_reg   <= 1'b0;
            sweep_cnt_reg      <= '0;
            rd_pend_reg        <= 1'b0;
            fill_reg           <= '0;
            offset_reg         <= 64'd0;
            v0_reg             <= 1'b0;
            v1_reg             <= 1'b0;
            v2_reg             <= 1'b0;
            out_valid_reg      <= 1'b0;
            count_reg          <= 7'd0;
        end
        else
        begin
            region_base_reg    <= region_base_next;
            pattern_length_reg <= pattern_length_next;
            match_limit_reg    <= match_limit_next;
            sweep_active_reg   <= sweep_active_next;
            sweep_cnt_reg      <= sweep_cnt_next;
            rd_pend_reg        <= rd_pend_next;
            fill_reg           <= fill_next;
            offset_reg         <= offset_next;
            v0_reg             <= v0_next;
            v1_reg             <= v1_next;
            v2_reg             <= v2_next;
            out_valid_reg      <= out_valid_next;
            count_reg          <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_acc)
        begin
            m0_reg <= m0_new;
        end
        if (adv)
        begin
            m1_reg      <= m0_reg;
            m2_reg      <= m2_new;
            group_reg   <= group_and;
            if (v2_reg)
            begin
                match_found_reg   <= hit;
                match_address_reg <= hit ? m2_reg.addr : 64'd0;
                match_count_reg   <= cnt_new;
                limit_reg         <= cnt_new >= match_limit_reg;
            end
        end
    end

    // Pattern memory: written by load items, read by the realignment sweep.
    always_ff @(posedge clk)
    begin
        if (load_acc && idx_in_range)
        begin
            pat_mem[IW'(entry_index)] <= load_entry;
        end
        pat_rdata_reg <= pat_mem[IW'(sweep_cnt_reg)];
    end

    assign cell_ctrl.win_shift = scan_acc;
    assign cell_ctrl.ap_shift  = rd_pend_reg;
    assign cell_ctrl.ap_write  = load_acc && load_hits;
    assign cell_ctrl.ok_en     = adv;

    for (genvar k = 0; k < PATTERN_DEPTH; k++)
    begin : g_cell
        localparam logic [LW-1:0] CELL_IDX = LW'(k);
        logic [7:0] win_prev;
        pat_entry_t ap_prev;

        if (k == 0)
        begin : g_head
            assign win_prev = data_byte;
            assign ap_prev  = pat_rdata_reg;
        end
        else
        begin : g_link
            assign win_prev = win_chain[k-1];
            assign ap_prev  = ap_chain[k-1];
        end

        wbps_cell u_cell (
            .clk     (clk),
            .ctrl    (cell_ctrl),
            .sel     (load_tgt == CELL_IDX),
            .active  (CELL_IDX < len_used),
            .win_in  (win_prev),
            .ap_in   (ap_prev),
            .ap_wr   (load_entry),
            .win_out (win_chain[k]),
            .ap_out  (ap_chain[k]),
            .ok      (ok_vec[k])
        );
    end

    always_comb
    begin
        ok_pad = '1;
        ok_pad[PATTERN_DEPTH-1:0] = ok_vec;
    end

    for (genvar g = 0; g < NG; g++)
    begin : g_group
        assign group_and[g] = &ok_pad[g*GROUP_SIZE +: GROUP_SIZE];
    end

    assign result_valid  = out_valid_reg;
    assign match_found   = match_found_reg;
    assign match_address = match_address_reg;
    assign match_count   = match_count_reg;
    assign limit_reached = limit_reg;

    `ASSERT_IMPLIES(a_sweep_blocks_items, clk, rst_n, sweep_busy, item_stall)
    `ASSERT_IMPLIES(a_found_has_count, clk, rst_n, result_valid && match_found, match_count != 7'd0)
    `ASSERT_IMPLIES(a_miss_zero_addr, clk, rst_n, result_valid && !match_found, match_address == 64'd0)
    `ASSERT_IMPLIES(a_count_steps, clk, rst_n, count_reg != $past(count_reg), (count_reg == ($past(count_reg) + 7'd1)) || (count_reg <= 7'd1))

endmodule
